// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_COLS = 80;
    localparam int TAB_STOP    = 8;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int ACT_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;
    localparam int TAB_W  = $clog2(TAB_STOP);

    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd144;
    localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DEL     = 8'h7F;

    localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WRITE,
        OP_LF,
        OP_CR,
        OP_BS,
        OP_TAB,
        OP_DEL,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] ch;
        logic [ROW_W-1:0]  rd_row;
        logic [COL_W-1:0]  rd_col;
        logic              rd_ok;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
`default_nettype none

// text console writer: character store plus cursor, driven one item at a time
// input: an item is taken at a rising edge with start high and busy low;
//   action selects put byte, cursor up, down, right, left or cell read; other codes only report
// result: one beat per item on the o_cursor_* and o_cell_* ports, valid for
//   exactly one cycle while o_strobe is high; the receiver cannot stall it
// config: i_cfg_valid/o_cfg_ready write the attribute byte used for every
//   byte put or cell blanked after the clearing pass; ready is always high
// result path: an accepted item waits in the queue, then the executor registers
//   its beat; a cell read also passes the registered read port of the store
// throughput: one item per cycle for moves and byte writes, while no cell read
//   (extra read state) or scroll holds the executor; a two-entry queue sits
//   between the decoder and the executor, busy rises when it fills
// scroll: a row overflow moves the store up one row and blanks the bottom
//   row, one cell per cycle through the single write port of the store
// reset: synchronous, active low; afterwards a clearing pass writes a blank
//   in the reset attribute to all 2000 cells, one per cycle, with busy high
module text_console_writer_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [tcw_pkg::ACT_W-1:0]  i_action,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_char_byte,
    input  wire logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  i_read_col,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_cfg_data,
    output logic                            o_strobe,
    output logic [tcw_pkg::ROW_W-1:0]       o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]       o_cursor_col,
    output logic [tcw_pkg::POS_W-1:0]       o_cursor_pos,
    output logic [tcw_pkg::BYTE_W-1:0]      o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]      o_cell_attr
);

    logic [tcw_pkg::BYTE_W-1:0] r_attr;
    tcw_pkg::t_cmd w_front_cmd;
    tcw_pkg::t_cmd w_head_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_empty;
    logic          w_full;
    logic          w_clearing;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_full | w_clearing;
    assign w_push      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_front u_front (
        .i_action   (i_action),
        .i_char_byte(i_char_byte),
        .i_read_row (i_read_row),
        .i_read_col (i_read_col),
        .o_cmd      (w_front_cmd)
    );

    tcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_front_cmd),
        .i_pop  (w_pop),
        .o_cmd  (w_head_cmd),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    tcw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     (r_attr),
        .i_cmd      (w_head_cmd),
        .i_cmd_valid(~w_empty),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_strobe   (o_strobe),
        .o_row      (o_cursor_row),
        .o_col      (o_cursor_col),
        .o_pos      (o_cursor_pos),
        .o_cell_char(o_cell_char),
        .o_cell_attr(o_cell_attr)
    );

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cursor_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)) &&
                     (o_cursor_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS)))
        else $error("cursor reported outside the screen");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("item could be taken before the clearing pass");

    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_strobe && w_empty)
        else $error("result beat or queued item during the clearing pass");

endmodule

`default_nettype wire

// ===== hdl/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tcw_front.sv =====
`default_nettype none

module tcw_front (
    input  wire logic [tcw_pkg::ACT_W-1:0]  i_action,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_char_byte,
    input  wire logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  i_read_col,
    output tcw_pkg::t_cmd                   o_cmd
);

    always_comb begin
        o_cmd.ch     = i_char_byte;
        o_cmd.rd_row = i_read_row;
        o_cmd.rd_col = i_read_col;
        o_cmd.rd_ok  = (i_read_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)) &&
                       (i_read_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS));
        unique case (i_action)
            tcw_pkg::ACT_PUT: begin
                unique case (i_char_byte)
                    tcw_pkg::CH_LF:  o_cmd.op = tcw_pkg::OP_LF;
                    tcw_pkg::CH_CR:  o_cmd.op = tcw_pkg::OP_CR;
                    tcw_pkg::CH_BS:  o_cmd.op = tcw_pkg::OP_BS;
                    tcw_pkg::CH_TAB: o_cmd.op = tcw_pkg::OP_TAB;
                    tcw_pkg::CH_DEL: o_cmd.op = tcw_pkg::OP_DEL;
                    default:         o_cmd.op = tcw_pkg::OP_WRITE;
                endcase
            end
            tcw_pkg::ACT_UP:    o_cmd.op = tcw_pkg::OP_UP;
            tcw_pkg::ACT_DOWN:  o_cmd.op = tcw_pkg::OP_DOWN;
            tcw_pkg::ACT_RIGHT: o_cmd.op = tcw_pkg::OP_RIGHT;
            tcw_pkg::ACT_LEFT:  o_cmd.op = tcw_pkg::OP_LEFT;
            tcw_pkg::ACT_READ:  o_cmd.op = tcw_pkg::OP_READ;
            default:            o_cmd.op = tcw_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tcw_queue.sv =====
`default_nettype none

module tcw_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire tcw_pkg::t_cmd i_cmd,
    input  wire logic    i_pop,
    output tcw_pkg::t_cmd o_cmd,
    output logic         o_empty,
    output logic         o_full
);

    tcw_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = ~r_wr;
        end
        if (i_pop) begin
            n_rd = ~r_rd;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rd];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
`default_nettype none

module tcw_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_attr,
    input  wire tcw_pkg::t_cmd              i_cmd,
    input  wire logic                       i_cmd_valid,
    output logic                            o_pop,
    output logic                            o_clearing,
    output logic                            o_strobe,
    output logic [tcw_pkg::ROW_W-1:0]       o_row,
    output logic [tcw_pkg::COL_W-1:0]       o_col,
    output logic [tcw_pkg::POS_W-1:0]       o_pos,
    output logic [tcw_pkg::BYTE_W-1:0]      o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]      o_cell_attr
);

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int TAB_W  = tcw_pkg::TAB_W;
    localparam int CELL_W = tcw_pkg::CELL_W;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(tcw_pkg::SCREEN_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(tcw_pkg::CELLS - tcw_pkg::SCREEN_COLS);

    tcw_pkg::t_state     r_state;
    tcw_pkg::t_state     n_state;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [ADDR_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]   n_cnt;
    logic                r_strobe;
    logic                n_strobe;
    logic [tcw_pkg::BYTE_W-1:0] r_cchar;
    logic [tcw_pkg::BYTE_W-1:0] n_cchar;
    logic [tcw_pkg::BYTE_W-1:0] r_cattr;
    logic [tcw_pkg::BYTE_W-1:0] n_cattr;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [CELL_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [CELL_W-1:0]   rdata;

    logic [ADDR_W-1:0]   w_pos;
    logic [CELL_W-1:0]   w_blank;
    logic [TAB_W:0]      w_delta;
    logic [COL_W:0]      w_tcol;

    assign w_pos   = tcw_pkg::cell_addr(r_row, r_col);
    assign w_blank = {i_attr, tcw_pkg::BLANK_CHAR};
    // distance to the next tab stop, always 1 to TAB_STOP
    assign w_delta = (TAB_W+1)'(tcw_pkg::TAB_STOP) - {1'b0, w_pos[TAB_W-1:0]};
    assign w_tcol  = {1'b0, r_col} + (COL_W+1)'(w_delta);

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(tcw_pkg::CELLS)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::ST_CLEAR;
            r_row    <= '0;
            r_col    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
        r_cchar <= n_cchar;
        r_cattr <= n_cattr;
    end

    always_comb begin
        logic emit;
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_cchar  = '0;
        n_cattr  = '0;
        we       = 1'b0;
        waddr    = w_pos;
        wdata    = w_blank;
        raddr    = w_pos;
        o_pop    = 1'b0;
        emit     = 1'b1;

        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CHAR};
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        tcw_pkg::OP_WRITE: begin
                            we    = 1'b1;
                            wdata = {i_attr, i_cmd.ch};
                            if (r_col < LAST_COL) begin
                                n_col = r_col + 1'b1;
                            end else begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                            end
                        end
                        tcw_pkg::OP_LF: begin
                            n_row = r_row + 1'b1;
                            n_col = '0;
                        end
                        tcw_pkg::OP_CR: begin
                            n_col = '0;
                        end
                        tcw_pkg::OP_BS: begin
                            if (w_pos != '0) begin
                                we    = 1'b1;
                                waddr = w_pos - 1'b1;
                                if (r_col == '0) begin
                                    n_col = LAST_COL;
                                    n_row = r_row - 1'b1;
                                end else begin
                                    n_col = r_col - 1'b1;
                                end
                            end
                        end
                        tcw_pkg::OP_TAB: begin
                            if (w_tcol >= (COL_W+1)'(tcw_pkg::SCREEN_COLS)) begin
                                n_col = COL_W'(w_tcol - (COL_W+1)'(tcw_pkg::SCREEN_COLS));
                                n_row = r_row + 1'b1;
                            end else begin
                                n_col = w_tcol[COL_W-1:0];
                            end
                        end
                        tcw_pkg::OP_DEL: begin
                            we = 1'b1;
                        end
                        tcw_pkg::OP_UP: begin
                            if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                            end
                        end
                        tcw_pkg::OP_DOWN: begin
                            if (r_row < LAST_ROW) begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        tcw_pkg::OP_RIGHT: begin
                            if (r_col < LAST_COL) begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcw_pkg::OP_LEFT: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        tcw_pkg::OP_READ: begin
                            if (i_cmd.rd_ok) begin
                                raddr   = tcw_pkg::cell_addr(i_cmd.rd_row, i_cmd.rd_col);
                                emit    = 1'b0;
                                n_state = tcw_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // cursor went past the bottom: scroll one row before reporting
                    if (n_row >= ROW_W'(tcw_pkg::SCREEN_ROWS)) begin
                        n_row   = LAST_ROW;
                        n_cnt   = '0;
                        emit    = 1'b0;
                        n_state = tcw_pkg::ST_COPY;
                    end
                    n_strobe = emit;
                end
            end

            tcw_pkg::ST_READ: begin
                n_strobe = 1'b1;
                n_cchar  = rdata[tcw_pkg::BYTE_W-1:0];
                n_cattr  = rdata[CELL_W-1:tcw_pkg::BYTE_W];
                n_state  = tcw_pkg::ST_IDLE;
            end

            tcw_pkg::ST_COPY: begin
                // read one row ahead, write the previous read back one row up
                if (r_cnt != COPY_END) begin
                    raddr = ADDR_W'(r_cnt + ADDR_W'(tcw_pkg::SCREEN_COLS));
                end
                we    = (r_cnt != '0);
                waddr = r_cnt - 1'b1;
                wdata = rdata;
                if (r_cnt == COPY_END) begin
                    n_state = tcw_pkg::ST_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            tcw_pkg::ST_BLANK: begin
                we    = 1'b1;
                waddr = r_cnt;
                if (r_cnt == LAST_CELL) begin
                    n_cnt    = '0;
                    n_strobe = 1'b1;
                    n_state  = tcw_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_clearing  = (r_state == tcw_pkg::ST_CLEAR);
    assign o_strobe    = r_strobe;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_pos       = tcw_pkg::POS_W'(w_pos);
    assign o_cell_char = r_cchar;
    assign o_cell_attr = r_cattr;

endmodule

`default_nettype wire

// ===== verif/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [tcw_pkg::ACT_W-1:0]  i_action,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_char_byte,
    input  wire logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  i_read_col,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       o_cfg_ready,
    input  wire logic [tcw_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic                       o_strobe,
    input  wire logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  o_cursor_col,
    input  wire logic [tcw_pkg::POS_W-1:0]  o_cursor_pos,
    input  wire logic [tcw_pkg::BYTE_W-1:0] o_cell_char,
    input  wire logic [tcw_pkg::BYTE_W-1:0] o_cell_attr,
    output int                              fail_count,
    output int                              pending,
    output int                              checked,
    output int                              scrolls
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
    } cursor_report_t;

    // shadow of the console: attribute in the high byte, character in the low byte
    logic [CELL_W-1:0] screen_cells [CELLS];
    int                cur_row;
    int                cur_col;
    logic [BYTE_W-1:0] text_attr;
    cursor_report_t    expected_reports [$];

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic cursor_report_t console_step(input logic [ACT_W-1:0]  act,
                                                    input logic [BYTE_W-1:0] ch,
                                                    input logic [ROW_W-1:0]  rr,
                                                    input logic [COL_W-1:0]  rc);
        cursor_report_t    rep;
        logic [CELL_W-1:0] blank;
        int                pos;
        rep = '0;
        blank = {text_attr, BLANK_CHAR};
        pos = cur_row * SCREEN_COLS + cur_col;
        case (act)
            ACT_PUT: begin
                case (ch)
                    CH_LF: begin
                        cur_row++;
                        cur_col = 0;
                    end
                    CH_CR: cur_col = 0;
                    CH_BS: begin
                        if (pos != 0) begin
                            screen_cells[pos - 1] = blank;
                            if (cur_col == 0) begin
                                cur_col = SCREEN_COLS - 1;
                                cur_row--;
                            end else begin
                                cur_col--;
                            end
                        end
                    end
                    CH_TAB: begin
                        pos = (pos / TAB_STOP + 1) * TAB_STOP;
                        cur_row = pos / SCREEN_COLS;
                        cur_col = pos % SCREEN_COLS;
                    end
                    CH_DEL: screen_cells[pos] = blank;
                    default: begin
                        screen_cells[pos] = {text_attr, ch};
                        if (cur_col < SCREEN_COLS - 1) begin
                            cur_col++;
                        end else begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                endcase
                // past the last row: shift everything up and blank the bottom row
                while (cur_row >= SCREEN_ROWS) begin
                    for (int i = 0; i < CELLS - SCREEN_COLS; i++)
                        screen_cells[i] = screen_cells[i + SCREEN_COLS];
                    for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
                        screen_cells[i] = blank;
                    cur_row--;
                    scrolls++;
                end
            end
            ACT_UP:    if (cur_row > 0) cur_row--;
            ACT_DOWN:  if (cur_row < SCREEN_ROWS - 1) cur_row++;
            ACT_RIGHT: if (cur_col < SCREEN_COLS - 1) cur_col++;
            ACT_LEFT:  if (cur_col > 0) cur_col--;
            ACT_READ: begin
                // cells off the screen read back as zero
                if (int'(rr) < SCREEN_ROWS && int'(rc) < SCREEN_COLS)
                    {rep.attr, rep.ch} = screen_cells[int'(rr) * SCREEN_COLS + int'(rc)];
            end
            default: ;
        endcase
        rep.row = ROW_W'(cur_row);
        rep.col = COL_W'(cur_col);
        rep.pos = POS_W'(cur_row * SCREEN_COLS + cur_col);
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        cursor_report_t got;
        cursor_report_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen_cells[i] = {ATTR_RESET, BLANK_CHAR};
            cur_row = 0;
            cur_col = 0;
            text_attr = ATTR_RESET;
            expected_reports.delete();
            fail_count = 0;
            checked = 0;
            scrolls = 0;
        end else begin
            if (o_strobe) begin
                got.row = o_cursor_row;
                got.col = o_cursor_col;
                got.pos = o_cursor_pos;
                got.ch = o_cell_char;
                got.attr = o_cell_attr;
                if (expected_reports.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing expected (row %0d col %0d)",
                                            got.row, got.col));
                end else begin
                    want = expected_reports.pop_front();
                    checked++;
                    if (got.row !== want.row)
                        flag_mismatch($sformatf("cursor_row %0d, expected %0d", got.row, want.row));
                    if (got.col !== want.col)
                        flag_mismatch($sformatf("cursor_col %0d, expected %0d", got.col, want.col));
                    if (got.pos !== want.pos)
                        flag_mismatch($sformatf("cursor_pos %0d, expected %0d", got.pos, want.pos));
                    if (got.ch !== want.ch)
                        flag_mismatch($sformatf("cell_char %h, expected %h", got.ch, want.ch));
                    if (got.attr !== want.attr)
                        flag_mismatch($sformatf("cell_attr %h, expected %h", got.attr, want.attr));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                text_attr = i_cfg_data;
            if (start && !busy)
                expected_reports.push_back(console_step(i_action, i_char_byte,
                                                        i_read_row, i_read_col));
        end
        pending = expected_reports.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import tcw_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = CELLS + 50;
    localparam int QUIET_LIMIT   = 10 * CELLS;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 100;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ACT_W-1:0]  i_action;
    logic [BYTE_W-1:0] i_char_byte;
    logic [ROW_W-1:0]  i_read_row;
    logic [COL_W-1:0]  i_read_col;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data;
    logic              o_strobe;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [COL_W-1:0]  o_cursor_col;
    logic [POS_W-1:0]  o_cursor_pos;
    logic [BYTE_W-1:0] o_cell_char;
    logic [BYTE_W-1:0] o_cell_attr;

    int fail_count;
    int pending;
    int checked;
    int scrolls;

    int quiet_cycles = 0;
    int seen_row = 0;
    int seen_col = 0;
    int n_items = 0;
    int n_puts = 0;
    int n_reads = 0;
    int attr_writes = 0;
    bit idling_on = 1'b1;

    logic [BYTE_W-1:0] attr_plan [PHASES] = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hA5, 8'hFF, 8'h07};

    text_console_writer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_char_byte  (i_char_byte),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

    tcw_checker console_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_char_byte  (i_char_byte),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .scrolls      (scrolls)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // the last reported cursor steers reads toward freshly written cells
    always @(posedge i_clk) begin
        if (o_strobe) begin
            seen_row <= int'(o_cursor_row);
            seen_col <= int'(o_cursor_col);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input logic [ACT_W-1:0]  act,
                             input logic [BYTE_W-1:0] ch,
                             input logic [ROW_W-1:0]  rr,
                             input logic [COL_W-1:0]  rc);
        if (idling_on && $urandom_range(0, 99) < 19) begin
            @(negedge i_clk);
            start = 1'b0;
            i_action = ACT_W'($urandom);
            i_char_byte = BYTE_W'($urandom);
            i_read_row = ROW_W'($urandom);
            i_read_col = COL_W'($urandom);
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        i_action = act;
        i_char_byte = ch;
        i_read_row = rr;
        i_read_col = rc;
        do @(posedge i_clk); while (busy);
        n_items++;
        if (act == ACT_PUT) n_puts++;
        if (act == ACT_READ) n_reads++;
    endtask

    task automatic send_put(input logic [BYTE_W-1:0] ch);
        send_item(ACT_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic send_read(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        send_item(ACT_READ, BYTE_W'($urandom), rr, rc);
    endtask

    task automatic send_action(input logic [ACT_W-1:0] act);
        send_item(act, BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic wait_drained(input int extra);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [BYTE_W-1:0] value);
        // drain every outstanding result first; a scroll gives its result beat only when it ends
        wait_drained(SETTLE_CYCLES);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = BYTE_W'($urandom);
        attr_writes++;
    endtask

    task automatic random_item();
        int                pick;
        int                col;
        logic [BYTE_W-1:0] ch;
        logic [ACT_W-1:0]  dir;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       dir = ACT_UP;
            1:       dir = ACT_DOWN;
            2:       dir = ACT_RIGHT;
            default: dir = ACT_LEFT;
        endcase
        if (pick < 55) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                ch = BYTE_W'($urandom_range(32, 126));
            end else if (pick < 85) begin
                case ($urandom_range(0, 4))
                    0:       ch = CH_LF;
                    1:       ch = CH_CR;
                    2:       ch = CH_BS;
                    3:       ch = CH_TAB;
                    default: ch = CH_DEL;
                endcase
            end else begin
                ch = BYTE_W'($urandom);
            end
            send_put(ch);
        end else if (pick < 72) begin
            send_action(dir);
        end else if (pick < 75) begin
            // a long run in one direction can pin the cursor against an edge
            repeat ($urandom_range(20, 85)) send_action(dir);
        end else if (pick < 95) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                col = seen_col - $urandom_range(0, 2);
                if (col < 0) col = 0;
                send_read(ROW_W'(seen_row), COL_W'(col));
            end else if (pick < 85) begin
                send_read(ROW_W'($urandom_range(0, SCREEN_ROWS - 1)),
                          COL_W'($urandom_range(0, SCREEN_COLS - 1)));
            end else begin
                send_read(ROW_W'($urandom), COL_W'($urandom));
            end
        end else begin
            send_action($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO);
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] attr_value;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ACT_PUT;
        i_char_byte = '0;
        i_read_row = '0;
        i_read_col = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: clamps, each control byte, plain bytes at the extremes, odd reads
        send_read(ROW_W'(0), COL_W'(0));
        send_put(CH_BS);
        send_action(ACT_LEFT);
        send_action(ACT_UP);
        send_put(8'h00);
        send_put(8'hFF);
        send_put(8'h41);
        send_read(ROW_W'(0), COL_W'(1));
        send_action(ACT_SPARE_LO);
        send_action(ACT_SPARE_HI);
        send_action(ACT_RIGHT);
        send_action(ACT_DOWN);
        send_put(CH_LF);
        send_put(CH_BS);
        send_put(CH_CR);
        send_put(CH_TAB);
        send_put(CH_TAB);
        send_put(CH_DEL);
        send_read(ROW_W'(31), COL_W'(127));
        send_read(ROW_W'(SCREEN_ROWS), COL_W'(0));
        send_read(ROW_W'(0), COL_W'(SCREEN_COLS));
        send_read(ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLS - 1));
        send_put(8'h7E);
        send_read(ROW_W'(1), COL_W'(16));

        for (int phase = 0; phase < PHASES; phase++) begin
            attr_value = (phase == 3 || phase == 5) ? BYTE_W'($urandom) : attr_plan[phase];
            write_attr(attr_value);
            idling_on = (phase != 2);
            while (n_items < 24 + PHASE_ITEMS * (phase + 1)) begin
                if ($urandom_range(0, 79) == 0)
                    wait_drained(0);
                random_item();
            end
        end

        wait_drained(SETTLE_CYCLES);
        $display("covered %0d items: %0d byte puts, %0d cell reads, %0d attribute writes",
                 n_items, n_puts, n_reads, attr_writes);
        $display("%0d result beats compared, %0d screen scrolls", checked, scrolls);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer_core.sv
verif/tcw_checker.sv
verif/tb.sv
